>>> rtl/sync_header_sample_deframer_macros.svh
// assertion macros for the sync header sample deframer
`ifndef SYNC_HEADER_SAMPLE_DEFRAMER_MACROS_SVH
`define SYNC_HEADER_SAMPLE_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SHSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SHSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHSD_ASSERT_IMP(lbl, ante, cons, msg)
`define SHSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/shsd_pkg.sv
// types and constants of the sync header sample deframer
package shsd_pkg;

  localparam logic [7:0]  SYNC_A         = 8'hAA;
  localparam logic [7:0]  SYNC_B         = 8'h55;
  localparam logic [31:0] FULL_SCALE_RST = 32'd2500000000;
  localparam int unsigned SCALE_SHIFT    = 23;
  localparam int unsigned CODE_W         = 24;
  localparam int unsigned SCALED_W       = 33;
  localparam int unsigned PROD_W         = CODE_W + SCALED_W;

  typedef struct packed {
    logic [2:0]               channel;
    logic signed [CODE_W-1:0] code;
    logic                     frame_last;
  } sample_t;

endpackage

>>> rtl/sync_header_sample_deframer.sv
// sync header sample deframer: byte parser, sample register and scaling output stage
// Takes one received byte per beat and can accept a byte in every cycle. Hunting looks
// for 0xAA, then 0x55 and a marker byte; the frame after that header yields CHANNELS
// big-endian 24-bit samples. Then bursts of FRAMES_PER_BURST frames follow, of which
// only the first header is checked; a bad burst gives no samples and hunting resumes.
// Each sample leaves as a signed code and floor(code * full_scale / 2^23). The byte
// that completes a sample makes the parser load the sample register, and then the
// multiplier fills the output register. in_ready_o drops only while both registers
// are full and the output is stalled. No clearing pass after reset.
`include "sync_header_sample_deframer_macros.svh"

module sync_header_sample_deframer #(
  parameter int unsigned CHANNELS         = 8,
  parameter int unsigned FRAME_BYTES      = 27,
  parameter int unsigned FRAMES_PER_BURST = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [31:0]                            cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [7:0]                             rx_byte_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [2:0]                             channel_o,
  output logic signed [shsd_pkg::CODE_W-1:0]     code_o,
  output logic signed [shsd_pkg::SCALED_W-1:0]   scaled_o,
  output logic                                   frame_last_o
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam int unsigned CH_W  = $clog2(CHANNELS + 1);
  localparam int unsigned FI_W  = (FRAMES_PER_BURST > 1) ? $clog2(FRAMES_PER_BURST) : 1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_PAIR_FIRST,
    PH_MARKER,
    PH_PAIR_SKIP,
    PH_FIRST_FRAME,
    PH_BURST
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [1:0]        sub_q, sub_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [15:0]       part_q, part_d;
  logic              bad_q, bad_d;
  logic [FI_W-1:0]   fidx_q, fidx_d;
  logic [31:0]       fs_q;

  logic              in_fire;
  logic              body;
  logic              samp_vld;
  logic [CH_W+2:0]   ch_ext;
  shsd_pkg::sample_t samp;

  logic              s1_vld_q;
  shsd_pkg::sample_t s1_q;
  logic              s1_free;
  logic              s2_adv;

  logic signed [shsd_pkg::PROD_W-1:0] mul_a;
  logic signed [shsd_pkg::PROD_W-1:0] mul_b;
  logic signed [shsd_pkg::PROD_W-1:0] prod;

  assign s2_adv     = !out_valid_o || out_ready_i;
  assign s1_free    = !s1_vld_q || s2_adv;
  assign in_ready_o = s1_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ch_ext          = (CH_W + 3)'(ch_q);
  assign samp.channel    = ch_ext[2:0];
  assign samp.code       = $signed({part_q, rx_byte_i});
  assign samp.frame_last = (ch_q == CH_W'(CHANNELS - 1));

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sub_d    = sub_q;
    ch_d     = ch_q;
    part_d   = part_q;
    bad_d    = bad_q;
    fidx_d   = fidx_q;
    body     = 1'b0;
    samp_vld = 1'b0;
    if (in_fire) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == shsd_pkg::SYNC_A) phase_d = PH_PAIR_FIRST;
        end
        PH_PAIR_FIRST: begin
          phase_d = (rx_byte_i == shsd_pkg::SYNC_B) ? PH_MARKER : PH_PAIR_SKIP;
        end
        PH_PAIR_SKIP: begin
          phase_d = PH_HUNT;
        end
        PH_MARKER: begin
          phase_d = PH_FIRST_FRAME;
          pos_d   = POS_W'(3);
          part_d  = '0;
          sub_d   = 2'd0;
          ch_d    = '0;
        end
        PH_FIRST_FRAME: begin
          body = 1'b1;
        end
        PH_BURST: begin
          // only the first header of a burst is checked
          if (fidx_q == '0 && pos_q == '0 && rx_byte_i != shsd_pkg::SYNC_A) bad_d = 1'b1;
          if (fidx_q == '0 && pos_q == POS_W'(1) && rx_byte_i != shsd_pkg::SYNC_B) begin
            bad_d = 1'b1;
          end
          body = (pos_q >= POS_W'(3));
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase

      if (body && ch_q < CH_W'(CHANNELS)) begin
        unique case (sub_q)
          2'd0: begin
            part_d = {rx_byte_i, 8'h00};
            sub_d  = 2'd1;
          end
          2'd1: begin
            part_d = {part_q[15:8], rx_byte_i};
            sub_d  = 2'd2;
          end
          default: begin
            sub_d    = 2'd0;
            ch_d     = ch_q + CH_W'(1);
            samp_vld = (phase_q == PH_FIRST_FRAME) || !bad_q;
          end
        endcase
      end

      if (phase_q == PH_FIRST_FRAME || phase_q == PH_BURST) begin
        if (pos_q == POS_W'(FRAME_BYTES - 1)) begin
          pos_d = '0;
          sub_d = 2'd0;
          ch_d  = '0;
          if (phase_q == PH_FIRST_FRAME) begin
            phase_d = PH_BURST;
            fidx_d  = '0;
            bad_d   = 1'b0;
          end else if (fidx_q == FI_W'(FRAMES_PER_BURST - 1)) begin
            fidx_d = '0;
            if (bad_d) begin
              bad_d   = 1'b0;
              phase_d = PH_HUNT;
            end
          end else begin
            fidx_d = fidx_q + FI_W'(1);
          end
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      sub_q   <= 2'd0;
      ch_q    <= '0;
      part_q  <= '0;
      bad_q   <= 1'b0;
      fidx_q  <= '0;
      fs_q    <= shsd_pkg::FULL_SCALE_RST;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sub_q   <= sub_d;
      ch_q    <= ch_d;
      part_q  <= part_d;
      bad_q   <= bad_d;
      fidx_q  <= fidx_d;
      if (cfg_we_i) fs_q <= cfg_wdata_i;
    end
  end

  // sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= in_fire && samp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_fire && samp_vld) s1_q <= samp;
  end

  // signed code times unsigned full scale, floor shift by taking the upper bits
  assign mul_a = shsd_pkg::PROD_W'(s1_q.code);
  assign mul_b = $signed({{(shsd_pkg::PROD_W - 32){1'b0}}, fs_q});
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_adv) begin
      out_valid_o <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_vld_q) begin
      channel_o    <= s1_q.channel;
      code_o       <= s1_q.code;
      scaled_o     <= prod[shsd_pkg::SCALE_SHIFT + shsd_pkg::SCALED_W - 1:shsd_pkg::SCALE_SHIFT];
      frame_last_o <= s1_q.frame_last;
    end
  end

  `SHSD_ASSERT_IMP(a_bad_only_in_burst, bad_q, phase_q == PH_BURST,
                   "burst error flag set outside a burst")
  `SHSD_ASSERT_IMP(a_ch_bound, 1'b1, ch_q <= CH_W'(CHANNELS),
                   "channel counter ran past the channel count")
  `SHSD_ASSERT_NXT(a_sample_held, s1_vld_q && !s2_adv, s1_vld_q,
                   "sample lost while output stalled")
  `SHSD_ASSERT_NXT(a_marker_to_frame, in_fire && phase_q == PH_MARKER,
                   phase_q == PH_FIRST_FRAME && pos_q == POS_W'(3) && ch_q == '0,
                   "first frame did not start after the marker byte")

endmodule

>>> sim/sync_header_sample_deframer_test.sv
// testbench for the sync header sample deframer: directed table, random byte stream, predictor
`timescale 1ns / 1ps

module sync_header_sample_deframer_test;

  localparam int unsigned CHANNELS         = 8;
  localparam int unsigned FRAME_BYTES      = 27;
  localparam int unsigned FRAMES_PER_BURST = 2;
  localparam int unsigned PHASE_ITEMS      = 190;
  localparam int unsigned DIR_ROWS         = 31;

  typedef enum logic [2:0] {
    ST_HUNT, ST_PAIR_FIRST, ST_MARKER, ST_PAIR_SKIP, ST_FIRST_FRAME, ST_BURST
  } deframe_state_e;

  typedef struct packed {
    logic [2:0]                           channel;
    logic signed [shsd_pkg::CODE_W-1:0]   code;
    logic signed [shsd_pkg::SCALED_W-1:0] scaled;
    logic                                 frame_last;
  } sample_result_t;

  typedef struct packed {
    logic [7:0]                           rx_byte;
    logic                                 typed;
    logic [2:0]                           channel;
    logic signed [shsd_pkg::CODE_W-1:0]   code;
    logic signed [shsd_pkg::SCALED_W-1:0] scaled;
    logic                                 frame_last;
  } stim_row_t;

  // typed results assume the reset full scale of 2500000000
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{8'h13, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hAA, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h55, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hAA, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h55, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h5A, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h7F, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hFF, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hFF, 1'b1, 3'd0, 24'sh7FFFFF, 33'sd2499999701, 1'b0},
    '{8'h80, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b1, 3'd1, 24'sh800000, -33'sd2500000000, 1'b0},
    '{8'hFF, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hFF, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hFF, 1'b1, 3'd2, -24'sd1, -33'sd299, 1'b0},
    '{8'h00, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b1, 3'd3, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h00, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h01, 1'b1, 3'd4, 24'sd1, 33'sd298, 1'b0},
    '{8'h12, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h34, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h56, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hA5, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hC3, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'h3C, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hFE, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hDC, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0},
    '{8'hBA, 1'b0, 3'd0, 24'sd0, 33'sd0, 1'b0}
  };

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [31:0]                          cfg_wdata_i;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic [7:0]                           rx_byte_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic [2:0]                           channel_o;
  logic signed [shsd_pkg::CODE_W-1:0]   code_o;
  logic signed [shsd_pkg::SCALED_W-1:0] scaled_o;
  logic                                 frame_last_o;

  sync_header_sample_deframer #(
    .CHANNELS        (CHANNELS),
    .FRAME_BYTES     (FRAME_BYTES),
    .FRAMES_PER_BURST(FRAMES_PER_BURST)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .channel_o   (channel_o),
    .code_o      (code_o),
    .scaled_o    (scaled_o),
    .frame_last_o(frame_last_o)
  );

  // predictor state
  deframe_state_e rx_state;
  int unsigned    frame_pos;
  int unsigned    frame_num;
  logic [15:0]    partial_word;
  bit             burst_corrupt;
  logic [31:0]    full_scale_cfg;

  sample_result_t pending_samples[$];
  int unsigned    mismatch_count;
  bit             no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // advance the deframer model by one byte, returns a sample when one completes
  task automatic deframe_byte(input logic [7:0] b, output bit produced,
                              output sample_result_t res);
    bit body;
    bit emit;
    bit advance;
    int unsigned slot;
    logic [23:0] raw;
    logic signed [shsd_pkg::PROD_W-1:0] product;
    produced = 1'b0;
    res = '0;
    body = 1'b0;
    emit = 1'b1;
    advance = 1'b0;
    case (rx_state)
      ST_HUNT: if (b == shsd_pkg::SYNC_A) rx_state = ST_PAIR_FIRST;
      ST_PAIR_FIRST: rx_state = (b == shsd_pkg::SYNC_B) ? ST_MARKER : ST_PAIR_SKIP;
      ST_PAIR_SKIP: rx_state = ST_HUNT;
      ST_MARKER: begin
        rx_state = ST_FIRST_FRAME;
        frame_pos = 3;
        partial_word = '0;
      end
      ST_FIRST_FRAME: begin
        body = 1'b1;
        advance = 1'b1;
      end
      ST_BURST: begin
        if (frame_num == 0 && frame_pos == 0 && b != shsd_pkg::SYNC_A) burst_corrupt = 1'b1;
        if (frame_num == 0 && frame_pos == 1 && b != shsd_pkg::SYNC_B) burst_corrupt = 1'b1;
        body = (frame_pos >= 3);
        emit = !burst_corrupt;
        advance = 1'b1;
      end
      default: rx_state = ST_HUNT;
    endcase
    if (body && frame_pos - 3 < 3 * CHANNELS) begin
      slot = frame_pos - 3;
      case (slot % 3)
        0: partial_word = {b, 8'h00};
        1: partial_word = partial_word | {8'h00, b};
        default: begin
          if (emit) begin
            raw = {partial_word, b};
            product = $signed(raw) * $signed({1'b0, full_scale_cfg});
            product = product >>> shsd_pkg::SCALE_SHIFT;
            res.channel = 3'(slot / 3);
            res.code = raw;
            res.scaled = product[shsd_pkg::SCALED_W-1:0];
            res.frame_last = (slot / 3 == CHANNELS - 1);
            produced = 1'b1;
          end
        end
      endcase
    end
    if (advance) begin
      frame_pos++;
      if (frame_pos >= FRAME_BYTES) begin
        frame_pos = 0;
        if (rx_state == ST_FIRST_FRAME) begin
          rx_state = ST_BURST;
          frame_num = 0;
          burst_corrupt = 1'b0;
        end else begin
          frame_num++;
          if (frame_num >= FRAMES_PER_BURST) begin
            frame_num = 0;
            if (burst_corrupt) begin
              burst_corrupt = 1'b0;
              rx_state = ST_HUNT;
            end
          end
        end
      end
    end
  endtask

  // sample content leans toward the code extremes
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed headers and bursts, with noise and broken headers mixed in
  function automatic logic [7:0] next_stream_byte();
    case (rx_state)
      ST_HUNT:
        return ($urandom_range(0, 99) < 80) ? shsd_pkg::SYNC_A : payload_byte();
      ST_PAIR_FIRST:
        return ($urandom_range(0, 99) < 85) ? shsd_pkg::SYNC_B : payload_byte();
      ST_BURST: begin
        if (frame_num == 0 && frame_pos == 0 && $urandom_range(0, 99) < 90)
          return shsd_pkg::SYNC_A;
        if (frame_num == 0 && frame_pos == 1 && $urandom_range(0, 99) < 90)
          return shsd_pkg::SYNC_B;
        return payload_byte();
      end
      default: return payload_byte();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, output bit produced,
                           output sample_result_t res);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_byte(b, produced, res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    // header and padding beats leave no result, give the pipeline time to empty
    repeat (4) @(posedge clk_i);
  endtask

  // sink side: stall at random and check every accepted beat
  initial begin
    sample_result_t want;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected sample ch=%0d code=%0d scaled=%0d last=%0b", $time,
                   channel_o, code_o, scaled_o, frame_last_o);
          mismatch_count++;
        end else begin
          want = pending_samples.pop_front();
          if (channel_o !== want.channel) begin
            $display("%0t: channel expected %0d actual %0d", $time, want.channel, channel_o);
            mismatch_count++;
          end
          if (code_o !== want.code) begin
            $display("%0t: code expected %0d actual %0d", $time, want.code, code_o);
            mismatch_count++;
          end
          if (scaled_o !== want.scaled) begin
            $display("%0t: scaled expected %0d actual %0d", $time, want.scaled, scaled_o);
            mismatch_count++;
          end
          if (frame_last_o !== want.frame_last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, want.frame_last,
                     frame_last_o);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin
    bit             produced;
    sample_result_t res;
    logic [31:0]    scale_plan [5];
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    rx_byte_i <= '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    rx_state = ST_HUNT;
    frame_pos = 0;
    frame_num = 0;
    partial_word = '0;
    burst_corrupt = 1'b0;
    full_scale_cfg = shsd_pkg::FULL_SCALE_RST;
    scale_plan = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0001, $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIRECTED_ROWS[i].rx_byte, produced, res);
      if (DIRECTED_ROWS[i].typed)
        pending_samples.push_back('{DIRECTED_ROWS[i].channel, DIRECTED_ROWS[i].code,
                                    DIRECTED_ROWS[i].scaled, DIRECTED_ROWS[i].frame_last});
      else if (produced)
        pending_samples.push_back(res);
    end

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= scale_plan[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      full_scale_cfg = scale_plan[p];
      // one whole phase runs with both sides streaming
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_byte(next_stream_byte(), produced, res);
        if (produced) pending_samples.push_back(res);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
